[rtl/gated_odometer_accumulator_unit_assert.svh]
// Assertion macros for the gated odometer accumulator.
`ifndef GATED_ODOMETER_ACCUMULATOR_UNIT_ASSERT_SVH
`define GATED_ODOMETER_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GOA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gated_odometer_accumulator_unit: check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GOA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gated_odometer_accumulator_unit: check failed");

`endif

[rtl/goa_pkg.sv]
// Package with item types, constants and the microcode table of the odometer.
package goa_pkg;

  localparam int TIME_W  = 48;
  localparam int VEL_W   = 24;
  localparam int DIST_W  = 63;
  localparam int MINSP_W = 23;
  localparam int MAXDT_W = 24;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 1;
  localparam int ROOT_STEPS = 24;
  localparam int CNT_W   = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_MIN_MOVE_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME_STEP  = 1'd1;

  typedef struct packed {
    logic                     mode;
    logic [TIME_W-1:0]        sample_time;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_z;
    logic signed [VEL_W-1:0]  speedo;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              counted;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DT,
    OP_SQX,
    OP_SQZ,
    OP_SUMSQ,
    OP_ROOT,
    OP_SPEED,
    OP_NOP,
    OP_MULDT,
    OP_ACC,
    OP_FINISH,
    OP_START
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_ITEM,
    C_START,
    C_NO_GATE,
    C_ROOT_BUSY,
    C_SLOW,
    C_OUT_BUSY
  } cond_t;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_DT     = 4'd1;
  localparam pc_t PC_GATE   = 4'd2;
  localparam pc_t PC_SQX    = 4'd3;
  localparam pc_t PC_SQZ    = 4'd4;
  localparam pc_t PC_SUMSQ  = 4'd5;
  localparam pc_t PC_ROOT   = 4'd6;
  localparam pc_t PC_SPEED  = 4'd7;
  localparam pc_t PC_MOVE   = 4'd8;
  localparam pc_t PC_MULDT  = 4'd9;
  localparam pc_t PC_ACC    = 4'd10;
  localparam pc_t PC_FINISH = 4'd11;
  localparam pc_t PC_START  = 4'd12;

  typedef struct packed {
    dp_op_t op;
    cond_t  cnd;
    pc_t    jmp;
    pc_t    nxt;
  } ucode_t;

  typedef struct packed {
    logic no_item;
    logic is_start;
    logic no_gate;
    logic root_busy;
    logic slow;
    logic out_busy;
  } seq_cond_t;

  typedef struct packed {
    dp_op_t op;
  } seq_ctrl_t;

  // The jump target is taken when the condition holds, otherwise nxt.
  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_IDLE:   w = '{op: OP_IDLE,   cnd: C_NO_ITEM,   jmp: PC_IDLE,   nxt: PC_DT};
      PC_DT:     w = '{op: OP_DT,     cnd: C_START,     jmp: PC_START,  nxt: PC_GATE};
      PC_GATE:   w = '{op: OP_NOP,    cnd: C_NO_GATE,   jmp: PC_FINISH, nxt: PC_SQX};
      PC_SQX:    w = '{op: OP_SQX,    cnd: C_NONE,      jmp: PC_IDLE,   nxt: PC_SQZ};
      PC_SQZ:    w = '{op: OP_SQZ,    cnd: C_NONE,      jmp: PC_IDLE,   nxt: PC_SUMSQ};
      PC_SUMSQ:  w = '{op: OP_SUMSQ,  cnd: C_NONE,      jmp: PC_IDLE,   nxt: PC_ROOT};
      PC_ROOT:   w = '{op: OP_ROOT,   cnd: C_ROOT_BUSY, jmp: PC_ROOT,   nxt: PC_SPEED};
      PC_SPEED:  w = '{op: OP_SPEED,  cnd: C_NONE,      jmp: PC_IDLE,   nxt: PC_MOVE};
      PC_MOVE:   w = '{op: OP_NOP,    cnd: C_SLOW,      jmp: PC_FINISH, nxt: PC_MULDT};
      PC_MULDT:  w = '{op: OP_MULDT,  cnd: C_NONE,      jmp: PC_IDLE,   nxt: PC_ACC};
      PC_ACC:    w = '{op: OP_ACC,    cnd: C_NONE,      jmp: PC_IDLE,   nxt: PC_FINISH};
      PC_FINISH: w = '{op: OP_FINISH, cnd: C_OUT_BUSY,  jmp: PC_FINISH, nxt: PC_IDLE};
      PC_START:  w = '{op: OP_START,  cnd: C_OUT_BUSY,  jmp: PC_START,  nxt: PC_IDLE};
      default:   w = '{op: OP_IDLE,   cnd: C_NONE,      jmp: PC_IDLE,   nxt: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/goa_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
module goa_seq
  import goa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_cond_t cond,
  output seq_ctrl_t ctrl
);

  pc_t    pc_r;
  pc_t    pc_nxt;
  ucode_t word;
  logic   take;

  always_comb begin
    word = ucode(pc_r);
    case (word.cnd)
      C_NO_ITEM:   take = cond.no_item;
      C_START:     take = cond.is_start;
      C_NO_GATE:   take = cond.no_gate;
      C_ROOT_BUSY: take = cond.root_busy;
      C_SLOW:      take = cond.slow;
      C_OUT_BUSY:  take = cond.out_busy;
      default:     take = 1'b0;
    endcase
    pc_nxt  = take ? word.jmp : word.nxt;
    ctrl.op = word.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[rtl/gated_odometer_accumulator_unit.sv]
// Gated odometer top level: datapath, configuration registers and result register.
// One item at a time: an item is taken only while the sequencer sits in its idle step.
// A counted sample spends most of its time in the 24-step square-root loop; a sample
// below the speed gate skips the multiply and add, one outside the time gate skips all
// arithmetic. The next item is taken as the result appears; a stalled result holds
// the sequencer. Synchronous reset clears the history and loads the register defaults.
module gated_odometer_accumulator_unit
  import goa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  `include "gated_odometer_accumulator_unit_assert.svh"

  seq_cond_t cond;
  seq_ctrl_t ctrl;

  logic [MINSP_W-1:0] min_speed_r;
  logic [MAXDT_W-1:0] max_step_r;
  logic [TIME_W-1:0]  prev_r;
  logic               have_prev_r;
  logic [DIST_W-1:0]  total_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  in_item_t               in_r;
  logic [TIME_W-1:0]      dt_r;
  logic                   later_r;
  logic                   counted_r;
  logic [2*VEL_W-1:0]     prod_r;
  logic [2*VEL_W-1:0]     rad_r;
  logic [VEL_W+1:0]       rem_r;
  logic [VEL_W-1:0]       root_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [VEL_W-1:0]       speed_r;

  logic [VEL_W-1:0]   vx_abs;
  logic [VEL_W-1:0]   vz_abs;
  logic [VEL_W-1:0]   mul_a;
  logic [VEL_W-1:0]   mul_b;
  logic [2*VEL_W-1:0] mul_p;
  logic               borrow;
  logic [TIME_W-1:0]  dt_diff;
  logic               gate_ok;
  logic [VEL_W+3:0]   rem_sh;
  logic [VEL_W+3:0]   trial;
  logic               fits;
  logic               sp_pos;
  logic [VEL_W-1:0]   sp_mag;
  logic [DIST_W:0]    acc_sum;
  logic               out_busy;
  logic               out_load;

  goa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  always_comb begin
    vx_abs = in_r.vel_x[VEL_W-1] ? VEL_W'(-in_r.vel_x) : in_r.vel_x;
    vz_abs = in_r.vel_z[VEL_W-1] ? VEL_W'(-in_r.vel_z) : in_r.vel_z;
    case (ctrl.op)
      OP_SQX: begin
        mul_a = vx_abs;
        mul_b = vx_abs;
      end
      OP_SQZ: begin
        mul_a = vz_abs;
        mul_b = vz_abs;
      end
      default: begin
        mul_a = speed_r;
        mul_b = dt_r[VEL_W-1:0];
      end
    endcase
    mul_p = mul_a * mul_b;

    {borrow, dt_diff} = {1'b0, in_r.sample_time} - {1'b0, prev_r};
    gate_ok = have_prev_r && later_r && (dt_r <= {{(TIME_W-MAXDT_W){1'b0}}, max_step_r});

    rem_sh = {rem_r, rad_r[2*VEL_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = (rem_sh >= trial);

    sp_pos = !in_r.speedo[VEL_W-1] && (in_r.speedo != '0);
    sp_mag = {1'b0, in_r.speedo[VEL_W-2:0]};

    acc_sum = {1'b0, total_r} + {{(DIST_W+1-2*VEL_W){1'b0}}, prod_r};

    out_busy = out_valid_r && out_stall;
    out_load = ((ctrl.op == OP_FINISH) || (ctrl.op == OP_START)) && !out_busy;

    cond.no_item   = !in_valid;
    cond.is_start  = in_r.mode;
    cond.no_gate   = !gate_ok;
    cond.root_busy = (cnt_r != CNT_W'(ROOT_STEPS - 1));
    cond.slow      = (speed_r < {1'b0, min_speed_r});
    cond.out_busy  = out_busy;
  end

  assign in_stall  = (ctrl.op != OP_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r <= MINSP_W'(26);
      max_step_r  <= MAXDT_W'(32768);
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_MOVE_SPEED: min_speed_r <= cfg_wdata[MINSP_W-1:0];
          REG_MAX_TIME_STEP:  max_step_r  <= cfg_wdata[MAXDT_W-1:0];
          default: ;
        endcase
      end
      unique case (ctrl.op)
        OP_ACC: begin
          total_r <= acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
        end
        OP_FINISH: begin
          prev_r      <= in_r.sample_time;
          have_prev_r <= 1'b1;
        end
        OP_START: begin
          prev_r      <= '0;
          have_prev_r <= 1'b0;
          total_r     <= '0;
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_item;
    end
    unique case (ctrl.op)
      OP_DT: begin
        dt_r      <= dt_diff;
        later_r   <= !borrow && (dt_diff != '0);
        counted_r <= 1'b0;
      end
      OP_SQX: begin
        prod_r <= mul_p;
      end
      OP_SQZ: begin
        prod_r <= mul_p;
        rad_r  <= prod_r;
      end
      OP_SUMSQ: begin
        rad_r  <= rad_r + prod_r;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      OP_ROOT: begin
        rad_r  <= {rad_r[2*VEL_W-3:0], 2'b00};
        root_r <= {root_r[VEL_W-2:0], fits};
        rem_r  <= fits ? (VEL_W+2)'(rem_sh - trial) : rem_sh[VEL_W+1:0];
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      OP_SPEED: begin
        speed_r <= (sp_pos && (sp_mag > root_r)) ? sp_mag : root_r;
      end
      OP_MULDT: begin
        prod_r <= mul_p;
      end
      OP_ACC: begin
        counted_r <= 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      if (ctrl.op == OP_START) begin
        out_item_r <= '{distance: '0, counted: 1'b0};
      end else begin
        out_item_r <= '{distance: total_r, counted: counted_r};
      end
    end
  end

  `GOA_ASSERT_NXT(a_dist_monotonic, ctrl.op != OP_START, total_r >= $past(total_r))
  `GOA_ASSERT_NXT(a_out_held, out_valid_r && out_stall, out_valid_r && $stable(out_item_r))
  `GOA_ASSERT_IMP(a_root_bounded, ctrl.op == OP_ROOT, cnt_r < CNT_W'(ROOT_STEPS))

endmodule
